### rtl/fdr_pkg.sv
// Shared types and constants of the dielectric Fresnel reflectance block.
// No dependencies; fdr_front, fdr_queue, fdr_back and the top import this package.
package fdr_pkg;

	// Field widths and fixed-point formats
	localparam int COS_W    = 16;               // signed Q1.15 cosine
	localparam int COS_FRAC = 15;
	localparam int ETA_W    = 16;               // unsigned Q4.12 index
	localparam int WORK     = 30;               // internal Q30 fraction
	localparam int CI_W     = COS_W + (WORK - COS_FRAC); // Q30 value up to 1.0
	localparam int PROD_W   = ETA_W + CI_W;     // index times Q30 value
	localparam int OUT_W    = 16;
	localparam int OUT_FRAC = 15;

	localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1) << OUT_FRAC;

	// Configuration registers
	localparam int REG_IDX_W = 1;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ETA_INCIDENT    = 1'b0,
		REG_ETA_TRANSMITTED = 1'b1
	} fdr_reg_t;

	localparam logic [ETA_W-1:0] ETA_I_RST = 16'd4096;
	localparam logic [ETA_W-1:0] ETA_T_RST = 16'd6144;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Classified item: cosine magnitude and the indices after the side swap
	typedef struct packed {
		logic [COS_W-1:0] cin;
		logic [ETA_W-1:0] ei;
		logic [ETA_W-1:0] et;
	} fdr_item_t;

endpackage

### rtl/fdr_front.sv
// Front end: index registers and classification of each incoming cosine.
// Depends on fdr_pkg.
module fdr_front
	import fdr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [ETA_W-1:0]     wr_data,
	input  logic [COS_W-1:0]     cos_incident,
	output fdr_item_t            item
);

	logic [ETA_W-1:0] eta_i_q;
	logic [ETA_W-1:0] eta_t_q;
	logic             neg;
	logic             exiting;

	// Write the index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_i_q <= ETA_I_RST;
			eta_t_q <= ETA_T_RST;
		end else if (wr_en) begin
			unique case (fdr_reg_t'(wr_index))
				REG_ETA_INCIDENT:    eta_i_q <= wr_data;
				REG_ETA_TRANSMITTED: eta_t_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Classify: a cosine of zero or below leaves the medium, so swap the indices.
	// The magnitude never exceeds 1.0 in Q1.15 (only the most negative code reaches it).
	assign neg     = cos_incident[COS_W-1];
	assign exiting = neg || (cos_incident == '0);

	always_comb begin
		item.cin = neg ? COS_W'(~cos_incident + COS_W'(1)) : cos_incident;
		item.ei  = exiting ? eta_t_q : eta_i_q;
		item.et  = exiting ? eta_i_q : eta_t_q;
	end

endmodule

### rtl/fdr_queue.sv
// Short FIFO between the front end and the arithmetic back end.
// Depends on fdr_pkg for the item type.
module fdr_queue
	import fdr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  fdr_item_t push_item,
	output logic      in_ready,
	input  logic      pop,
	output logic      out_vld,
	output fdr_item_t out_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fdr_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign in_ready = (count_q != CNT_W'(DEPTH));
	assign out_vld  = (count_q != '0);
	assign out_item = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CNT_W'($past(push)) - CNT_W'($past(pop)))
		else $error("queue fill count lost track of push and pop");
`endif

endmodule

### rtl/fdr_isqrt_pipe.sv
// Pipelined integer square root, one result digit per stage, with a sideband.
// Depends on no package.
module fdr_isqrt_pipe #(
	parameter int RW = 31,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [2*RW-1:0] rad,
	input  logic [SW-1:0]   side_in,
	output logic            out_vld,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);

	logic            vld_q  [RW];
	logic [2*RW-1:0] rad_q  [RW];
	logic [RW:0]     rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [SW-1:0]   side_q [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stg
		logic            v_d;
		logic [2*RW-1:0] rad_d;
		logic [RW:0]     rem_d;
		logic [RW-1:0]   root_d;
		logic [SW-1:0]   side_d;
		logic [RW+1:0]   rem_n;
		logic [RW+1:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_d    = in_vld;
			assign rad_d  = rad;
			assign rem_d  = '0;
			assign root_d = '0;
			assign side_d = side_in;
		end else begin : g_next
			assign v_d    = vld_q[k-1];
			assign rad_d  = rad_q[k-1];
			assign rem_d  = rem_q[k-1];
			assign root_d = root_q[k-1];
			assign side_d = side_q[k-1];
		end

		// Bring down two radicand bits and try the next root digit
		assign rem_n = {rem_d[RW-1:0], rad_d[2*RW-1 -: 2]};
		assign trial = {root_d, 2'b01};
		assign ge    = (rem_n >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k]  <= rad_d << 2;
				rem_q[k]  <= ge ? (RW+1)'(rem_n - trial) : rem_n[RW:0];
				root_q[k] <= {root_d[RW-2:0], ge};
				side_q[k] <= side_d;
			end
		end
	end

	assign out_vld  = vld_q[RW-1];
	assign root     = root_q[RW-1];
	assign side_out = side_q[RW-1];

endmodule

### rtl/fdr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// The starting remainder must be below the divisor. Depends on no package.
module fdr_div_pipe #(
	parameter int DW = 16,
	parameter int NB = 30,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] rem0,
	input  logic [DW-1:0] den,
	input  logic [NB-1:0] feed,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [NB-1:0] quot,
	output logic [SW-1:0] side_out
);

	logic          vld_q  [NB];
	logic [DW-1:0] rem_q  [NB];
	logic [DW-1:0] den_q  [NB];
	logic [NB-1:0] feed_q [NB];
	logic [NB-1:0] quot_q [NB];
	logic [SW-1:0] side_q [NB];

	for (genvar k = 0; k < NB; k++) begin : g_stg
		logic          v_d;
		logic [DW-1:0] rem_d;
		logic [DW-1:0] den_d;
		logic [NB-1:0] feed_d;
		logic [NB-1:0] quot_d;
		logic [SW-1:0] side_d;
		logic [DW:0]   rem_n;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_d    = in_vld;
			assign rem_d  = rem0;
			assign den_d  = den;
			assign feed_d = feed;
			assign quot_d = '0;
			assign side_d = side_in;
		end else begin : g_next
			assign v_d    = vld_q[k-1];
			assign rem_d  = rem_q[k-1];
			assign den_d  = den_q[k-1];
			assign feed_d = feed_q[k-1];
			assign quot_d = quot_q[k-1];
			assign side_d = side_q[k-1];
		end

		// Shift in the next dividend bit and subtract where it fits
		assign rem_n = {rem_d, feed_d[NB-1]};
		assign ge    = (rem_n >= {1'b0, den_d});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? DW'(rem_n - {1'b0, den_d}) : rem_n[DW-1:0];
				den_q[k]  <= den_d;
				feed_q[k] <= feed_d << 1;
				quot_q[k] <= {quot_d[NB-2:0], ge};
				side_q[k] <= side_d;
			end
		end
	end

	assign out_vld  = vld_q[NB-1];
	assign quot     = quot_q[NB-1];
	assign side_out = side_q[NB-1];

endmodule

### rtl/fdr_back.sv
// Back end: sine, Snell ratio, cosine of transmission, Fresnel ratios, result.
// Depends on fdr_pkg, fdr_isqrt_pipe and fdr_div_pipe.
module fdr_back
	import fdr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_vld,
	input  fdr_item_t        item,
	output logic             item_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_refl,
	output logic             out_tir
);

	localparam int ITEM_W = $bits(fdr_item_t);
	localparam int RAD_W  = 2 * CI_W;           // square-root radicand
	localparam int ST_W   = WORK;               // transmitted sine below 1.0
	localparam int RAT_W  = PROD_W;             // ratio operands
	localparam int SQ_W   = 2 * CI_W;           // squared ratio
	localparam int RND_SH = 2 * WORK - OUT_FRAC;
	localparam int R_W    = SQ_W + 1 - RND_SH;  // rounded result before saturation
	localparam logic [CI_W-1:0] Q30_ONE = CI_W'(1) << WORK;

	typedef struct packed {
		logic      tir;
		fdr_item_t it;
	} fdr_tag_t;

	logic en;

	// Whole pipeline advances unless a finished result is held back
	assign en       = !out_valid || out_ready;
	assign item_pop = en && item_vld;

	// Stage 1: radicand for the sine of incidence, (1 - cos^2) in Q60
	logic             vld_s1;
	fdr_item_t        it_s1;
	logic [RAD_W-1:0] rad1_s1;
	logic [2*COS_W-1:0] cin_sq;

	assign cin_sq = (2*COS_W)'(item.cin) * (2*COS_W)'(item.cin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= item;
			rad1_s1 <= {1'b0, CI_W'(Q30_ONE - CI_W'(cin_sq)), WORK'(0)};
		end
	end

	// Sine of incidence
	logic            vld_si;
	logic [CI_W-1:0] si;
	fdr_item_t       it_si;

	fdr_isqrt_pipe #(.RW(CI_W), .SW(ITEM_W)) u_sqrt_si (
		.clk, .arst_n, .en,
		.in_vld(vld_s1), .rad(rad1_s1), .side_in(it_s1),
		.out_vld(vld_si), .root(si), .side_out(it_si)
	);

	// Stage 2: scaled sine, ei * sI
	logic              vld_s2;
	fdr_item_t         it_s2;
	logic [PROD_W-1:0] p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_si;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_si;
			p_s2  <= PROD_W'(it_si.ei) * PROD_W'(si);
		end
	end

	// Stage 3: total internal reflection test, ei * sI >= et * 1.0
	logic              vld_s3;
	fdr_tag_t          tag_s3;
	logic [PROD_W-1:0] p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3.it  <= it_s2;
			tag_s3.tir <= (p_s2 >= {1'b0, it_s2.et, WORK'(0)});
			p_s3       <= p_s2;
		end
	end

	// Transmitted sine, (ei * sI) / et; the high part is below et when not reflected
	logic            vld_st;
	logic [ST_W-1:0] st;
	fdr_tag_t        tag_st;

	fdr_div_pipe #(.DW(ETA_W), .NB(ST_W), .SW($bits(fdr_tag_t))) u_div_st (
		.clk, .arst_n, .en,
		.in_vld(vld_s3), .rem0(p_s3[WORK +: ETA_W]), .den(tag_s3.it.et),
		.feed(p_s3[WORK-1:0]), .side_in(tag_s3),
		.out_vld(vld_st), .quot(st), .side_out(tag_st)
	);

	// Stage 4: square of the transmitted sine
	logic              vld_s4;
	fdr_tag_t          tag_s4;
	logic [2*ST_W-1:0] st_sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_st;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4   <= tag_st;
			st_sq_s4 <= (2*ST_W)'(st) * (2*ST_W)'(st);
		end
	end

	// Stage 5: radicand for the transmitted cosine
	logic             vld_s5;
	fdr_tag_t         tag_s5;
	logic [RAD_W-1:0] rad2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s5  <= tag_s4;
			rad2_s5 <= (RAD_W'(1) << (2 * WORK)) - RAD_W'(st_sq_s4);
		end
	end

	// Transmitted cosine
	logic            vld_ct;
	logic [CI_W-1:0] ct;
	fdr_tag_t        tag_ct;

	fdr_isqrt_pipe #(.RW(CI_W), .SW($bits(fdr_tag_t))) u_sqrt_ct (
		.clk, .arst_n, .en,
		.in_vld(vld_s5), .rad(rad2_s5), .side_in(tag_s5),
		.out_vld(vld_ct), .root(ct), .side_out(tag_ct)
	);

	// Stage 6: the four index-cosine products
	logic              vld_s6;
	logic              tir_s6;
	logic [PROD_W-1:0] a_s6;
	logic [PROD_W-1:0] b_s6;
	logic [PROD_W-1:0] c_s6;
	logic [PROD_W-1:0] d_s6;
	logic [CI_W-1:0]   ci;

	assign ci = {tag_ct.it.cin, (WORK - COS_FRAC)'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_ct;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s6 <= tag_ct.tir;
			a_s6   <= PROD_W'(tag_ct.it.et) * PROD_W'(ci);
			b_s6   <= PROD_W'(tag_ct.it.ei) * PROD_W'(ct);
			c_s6   <= PROD_W'(tag_ct.it.ei) * PROD_W'(ci);
			d_s6   <= PROD_W'(tag_ct.it.et) * PROD_W'(ct);
		end
	end

	// Stage 7: numerators as magnitudes, and denominators
	logic             vld_s7;
	logic             tir_s7;
	logic [RAT_W-1:0] na_s7;
	logic [RAT_W-1:0] da_s7;
	logic [RAT_W-1:0] ne_s7;
	logic [RAT_W-1:0] de_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s7 <= tir_s6;
			na_s7  <= (a_s6 >= b_s6) ? a_s6 - b_s6 : b_s6 - a_s6;
			da_s7  <= a_s6 + b_s6;
			ne_s7  <= (c_s6 >= d_s6) ? c_s6 - d_s6 : d_s6 - c_s6;
			de_s7  <= c_s6 + d_s6;
		end
	end

	// Stage 8: integer bit of each ratio; flag zero denominators
	logic             vld_s8;
	logic             tir_s8;
	logic             q0a_s8;
	logic             q0e_s8;
	logic             zda_s8;
	logic             zde_s8;
	logic [RAT_W-1:0] ra_s8;
	logic [RAT_W-1:0] re_s8;
	logic [RAT_W-1:0] da_s8;
	logic [RAT_W-1:0] de_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s8 <= tir_s7;
			q0a_s8 <= (na_s7 >= da_s7);
			q0e_s8 <= (ne_s7 >= de_s7);
			zda_s8 <= (da_s7 == '0);
			zde_s8 <= (de_s7 == '0);
			ra_s8  <= (na_s7 >= da_s7) ? na_s7 - da_s7 : na_s7;
			re_s8  <= (ne_s7 >= de_s7) ? ne_s7 - de_s7 : ne_s7;
			da_s8  <= da_s7;
			de_s8  <= de_s7;
		end
	end

	// Fraction bits of both ratios, side by side
	logic            vld_ra;
	logic            vld_re;
	logic [WORK-1:0] qa;
	logic [WORK-1:0] qe;
	logic [2:0]      side_a;
	logic [1:0]      side_e;

	fdr_div_pipe #(.DW(RAT_W), .NB(WORK), .SW(3)) u_div_parl (
		.clk, .arst_n, .en,
		.in_vld(vld_s8), .rem0(ra_s8), .den(da_s8), .feed('0),
		.side_in({tir_s8, q0a_s8, zda_s8}),
		.out_vld(vld_ra), .quot(qa), .side_out(side_a)
	);

	fdr_div_pipe #(.DW(RAT_W), .NB(WORK), .SW(2)) u_div_perp (
		.clk, .arst_n, .en,
		.in_vld(vld_s8 && !tir_s8), .rem0(re_s8), .den(de_s8), .feed('0),
		.side_in({q0e_s8, zde_s8}),
		.out_vld(vld_re), .quot(qe), .side_out(side_e)
	);

	// Stage 9: squared ratios; a zero denominator means 1.0
	logic            vld_s9;
	logic            tir_s9;
	logic [SQ_W-1:0] sqa_s9;
	logic [SQ_W-1:0] sqe_s9;
	logic [CI_W-1:0] rpa;
	logic [CI_W-1:0] rpe;

	assign rpa = side_a[0] ? Q30_ONE : {side_a[1], qa};
	assign rpe = side_e[0] ? Q30_ONE : {side_e[1], qe};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_ra;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s9 <= side_a[2];
			sqa_s9 <= SQ_W'(rpa) * SQ_W'(rpa);
			sqe_s9 <= SQ_W'(rpe) * SQ_W'(rpe);
		end
	end

	// Output register: halve, round to nearest with ties up, saturate; total internal reflection gives 1.0
	logic [SQ_W:0]               sum;
	logic [SQ_W+1:0]             rnd;
	logic [R_W-1:0]              r;
	logic [OUT_W-1:0]            refl_q;
	logic                        tir_q;
	logic                        out_vld_q;

	assign sum = (SQ_W+1)'(sqa_s9) + (SQ_W+1)'(sqe_s9);
	assign rnd = (SQ_W+2)'(sum) + ((SQ_W+2)'(1) << RND_SH);
	assign r   = rnd[SQ_W+1:RND_SH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_q  <= tir_s9;
			refl_q <= (tir_s9 || (r > R_W'(OUT_ONE))) ? OUT_ONE : OUT_W'(r);
		end
	end

	assign out_valid = out_vld_q;
	assign out_refl  = refl_q;
	assign out_tir   = tir_q;

`ifndef SYNTHESIS
	a_ratio_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vld_re |-> vld_ra)
		else $error("perpendicular ratio lane out of step with parallel lane");
`endif

endmodule

### rtl/fresnel_dielectric_reflectance_top.sv
// Dielectric Fresnel reflectance: cosine in, unpolarized reflectance out, one item per clock.
// Accepts one cosine per clock and delivers one result per clock while the output is taken.
// An item passes from acceptance through the input queue, then two 31-stage square-root
// pipelines (sine of incidence and transmitted cosine) and three 30-stage divider pipelines
// (Snell ratio, then both Fresnel ratios side by side), plus ten stages of multiplies,
// compares and rounding. A stalled output holds the whole back end; the four-entry input
// queue keeps taking items until it fills.
// Depends on fdr_pkg, fdr_front, fdr_queue, fdr_isqrt_pipe, fdr_div_pipe and fdr_back.
module fresnel_dielectric_reflectance_top
	import fdr_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input request
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [COS_W-1:0]     s_axis_tdata,   // [15:0] cos_incident
	// result request
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_W-1:0]     m_axis_tdata,   // [15:0] reflectance
	output logic [0:0]           m_axis_tuser,   // [0] total_internal
	// configuration writes
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [ETA_W-1:0]     wr_data
);

	fdr_item_t front_item;
	fdr_item_t queue_item;
	logic      push;
	logic      pop;
	logic      queue_vld;
	logic      tir;

	assign push = s_axis_tvalid && s_axis_tready;

	// Classify incoming cosines against the index registers
	fdr_front u_front (
		.clk, .arst_n,
		.wr_en, .wr_index, .wr_data,
		.cos_incident(s_axis_tdata),
		.item(front_item)
	);

	// Decouple acceptance from the arithmetic pipeline
	fdr_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n,
		.push, .push_item(front_item), .in_ready(s_axis_tready),
		.pop, .out_vld(queue_vld), .out_item(queue_item)
	);

	// Evaluate reflectance
	fdr_back u_back (
		.clk, .arst_n,
		.item_vld(queue_vld), .item(queue_item), .item_pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_refl(m_axis_tdata), .out_tir(tir)
	);

	assign m_axis_tuser = tir;

`ifndef SYNTHESIS
	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == OUT_ONE)
		else $error("total internal reflection without full reflectance");

	a_refl_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= OUT_ONE)
		else $error("reflectance above 1.0");
`endif

endmodule

### test/tb.sv
// Testbench for fresnel_dielectric_reflectance_top: drives cosines, predicts reflectance.
// Depends on fdr_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 100ps

// Holds the expected reflectance results in request order
class reflectance_board;
	logic [16:0] pending[$];
	int errors;
	logic [15:0] eta_i, eta_t;

	function new();
		errors = 0;
		eta_i = 16'd4096;
		eta_t = 16'd6144;
	endfunction

	static function logic [63:0] root64(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	static function logic [63:0] frac_q30(logic [63:0] num, logic [63:0] den);
		logic [63:0] q, rem;
		if (den == 0) return 64'd1 << 30;
		q = 0;
		rem = num;
		if (rem >= den) begin
			rem = rem - den;
			q = 1;
		end
		for (int i = 0; i < 30; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// Compute {total_internal, reflectance} for one cosine
	function logic [16:0] reflect(logic [15:0] cosv);
		logic [63:0] mag, ei, et, ci, si, st, ct, a, b, c, d, rpa, rpe, sum, r, one2;
		mag = cosv[15] ? (64'h10000 - cosv) : cosv;
		ei = eta_i;
		et = eta_t;
		if (cosv[15] || cosv == 0) begin
			ei = eta_t;
			et = eta_i;
		end
		if (mag > 64'd32768) mag = 64'd32768;
		ci = mag << 15;
		one2 = 64'd1 << 60;
		si = root64(one2 - ci * ci);
		if (ei * si >= et << 30) return {1'b1, 16'd32768};
		st = (ei * si) / et;
		ct = root64(one2 - st * st);
		a = et * ci;
		b = ei * ct;
		c = ei * ci;
		d = et * ct;
		rpa = frac_q30(a >= b ? a - b : b - a, a + b);
		rpe = frac_q30(c >= d ? c - d : d - c, c + d);
		sum = rpa * rpa + rpe * rpe;
		r = (sum + (64'd1 << 45)) >> 46;
		if (r > 64'd32768) r = 64'd32768;
		return {1'b0, r[15:0]};
	endfunction

	function void note_request(logic [15:0] cosv);
		pending.push_back(reflect(cosv));
	endfunction

	function void check_result(logic [15:0] refl, logic tir);
		logic [16:0] exp_v;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result refl=%0d tir=%0d", $time, refl, tir);
			errors++;
			return;
		end
		exp_v = pending.pop_front();
		if (exp_v[15:0] !== refl) begin
			$display("%0t: reflectance expected %0d actual %0d", $time, exp_v[15:0], refl);
			errors++;
		end
		if (exp_v[16] !== tir) begin
			$display("%0t: total_internal expected %0d actual %0d", $time, exp_v[16], tir);
			errors++;
		end
	endfunction
endclass

module tb;
	import fdr_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [COS_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic wr_en = 0;
	logic [REG_IDX_W-1:0] wr_index = REG_ETA_INCIDENT;
	logic [ETA_W-1:0] wr_data = '0;

	reflectance_board board = new();
	int idle_cycles = 0;
	bit hold_off = 0;
	int stall_mode = 0;

	localparam int LATENCY = 140;
	localparam int WATCHDOG = 5000;

	fresnel_dielectric_reflectance_top DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Check results and count cycles with no request moving
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser[0]);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("FAIL fresnel_dielectric_reflectance_top");
			$finish;
		end
	end

	// Receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_off)
			m_axis_tready <= 0;
		else case (stall_mode)
			0: m_axis_tready <= 1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= $urandom_range(0, 1);
		endcase
	end

	task automatic send_cos(logic [15:0] cosv);
		s_axis_tvalid <= 1;
		s_axis_tdata <= cosv;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_request(cosv);
	endtask

	task automatic pause_sender(int n);
		s_axis_tvalid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// Bursts of random cosines with random gaps
	task automatic send_random(int n);
		int burst;
		logic [15:0] cosv;
		while (n > 0) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && n > 0; i++, n--) begin
				case ($urandom_range(0, 5))
					0: cosv = $urandom_range(32760, 32775);
					1: cosv = 16'h8000 + $urandom_range(0, 6);
					2: cosv = $urandom_range(0, 64);
					default: cosv = $urandom;
				endcase
				send_cos(cosv);
			end
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
		end
		s_axis_tvalid <= 0;
	endtask

	// Wait until every request has its result, then a little longer
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(fdr_reg_t idx, logic [15:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
		@(posedge clk);
		if (idx == REG_ETA_INCIDENT) board.eta_i = val;
		else board.eta_t = val;
	endtask

	initial begin
		logic [15:0] dir_cos[] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF,
			16'h0001, 16'h8000 + 16'd1, 16'd16384, -16'sd16384, 16'd32767,
			16'hAAAA, 16'h5555, 16'd100, -16'sd100};
		logic [15:0] eta_set[][2] = '{'{16'd4096, 16'd6144}, '{16'd1, 16'd65535},
			'{16'd65535, 16'd1}, '{16'd6144, 16'd4096}, '{16'd4096, 16'd4096},
			'{16'd5461, 16'd9830}};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed cosines at reset indices
		foreach (dir_cos[i]) send_cos(dir_cos[i]);
		pause_sender(1);
		drain();

		// Long receiver hold-off while the sender keeps offering
		hold_off = 1;
		fork
			send_random(250);
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();

		// Walk through index settings, extremes included
		foreach (eta_set[k]) begin
			write_reg(REG_ETA_INCIDENT, eta_set[k][0]);
			write_reg(REG_ETA_TRANSMITTED, eta_set[k][1]);
			stall_mode = k % 3;
			foreach (dir_cos[i]) if (i < 6) send_cos(dir_cos[i]);
			send_random(60);
			drain();
		end
		write_reg(REG_ETA_INCIDENT, $urandom_range(1, 65535));
		write_reg(REG_ETA_TRANSMITTED, $urandom_range(1, 65535));
		stall_mode = 1;
		send_random(60);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS fresnel_dielectric_reflectance_top");
		else
			$display("FAIL fresnel_dielectric_reflectance_top");
		$finish;
	end
endmodule
